/* rtl/dledf_pkg.sv */
// shared types and constants for the dle/stx/etx deframer
`timescale 1ns / 1ps

package dledf_pkg;

	// configuration register indexes
	localparam int unsigned RegIdxW = 2;
	typedef enum logic [RegIdxW-1:0] {
		REG_CHECKSUM_ENABLE = 2'd0,
		REG_ESCAPE_CODE     = 2'd1,
		REG_START_CODE      = 2'd2,
		REG_END_CODE        = 2'd3
	} reg_idx_t;

	localparam int unsigned CfgDataW = 8;

	// reset values of the configuration registers
	localparam logic        ChecksumEnableRst = 1'b1;
	localparam logic [7:0]  EscapeCodeRst     = 8'h10;
	localparam logic [7:0]  StartCodeRst      = 8'h02;
	localparam logic [7:0]  EndCodeRst        = 8'h03;

	// result event codes
	typedef enum logic [1:0] {
		EV_PAYLOAD  = 2'd0,
		EV_GOOD     = 2'd1,
		EV_ABORT    = 2'd2,
		EV_MISMATCH = 2'd3
	} event_t;

endpackage

/* rtl/dledf_rx_if.sv */
// byte channel carrying raw received bytes
`timescale 1ns / 1ps

interface dledf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/dledf_res_if.sv */
// result channel carrying deframed bytes and frame events
`timescale 1ns / 1ps

interface dledf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] event_res;

	modport source (output valid, output out_byte, output event_res, input ready);
	modport sink   (input valid, input out_byte, input event_res, output ready);
endinterface

/* rtl/dle_stx_etx_deframer_checksum_unit.sv */
// dle/stx/etx byte-stuffing deframer with optional complement checksum
`timescale 1ns / 1ps

// Deframes a byte stream framed as escape/start ... escape/end, one raw byte
// per rx beat. Payload bytes come out with event 0; a doubled escape gives one
// escape payload byte. With checksum_enable set, the byte after escape/end must
// equal the complement of the 8-bit sum of the payload (stuffed escapes
// included) and gives event 1 (good) or 3 (mismatch); with it clear the end pair
// gives event 1 at once. Escape followed by any other byte gives event 2 and
// drops back to hunting. The start pair, the escape opening each escape pair,
// the end code with checksum_enable set and bytes seen while hunting give no
// result beat. Each rx beat is taken into an input register and decoded from
// there into a one-deep result register, so the block sustains one byte per
// cycle while res is ready. A res stall holds the result register and backs
// up into rx after at most one more byte. Configuration is written through
// wr_en/wr_index/wr_data and must only change while no byte is in flight.
module dle_stx_etx_deframer_checksum_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [dledf_pkg::RegIdxW-1:0]         wr_index,
	input  logic [dledf_pkg::CfgDataW-1:0]        wr_data,
	dledf_rx_if.sink                              rx,
	dledf_res_if.source                           res
);

	// decoder phases
	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_START = 3'd1,
		PH_DATA  = 3'd2,
		PH_ESC   = 3'd3,
		PH_CHECK = 3'd4
	} phase_t;

	// configuration registers
	logic       checksum_enable_q;
	logic [7:0] escape_code_q;
	logic [7:0] start_code_q;
	logic [7:0] end_code_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// decoder state and result register
	phase_t            phase_q;
	logic [7:0]        sum_q;
	logic              res_valid_q;
	logic [7:0]        res_byte_q;
	dledf_pkg::event_t res_event_q;

	// next-state logic
	phase_t            phase_d;
	logic [7:0]        sum_d;
	logic              emit_d;
	dledf_pkg::event_t event_d;
	logic [7:0]        sum_plus;
	logic              advance;

	// the decode stage moves when the result register is free or drains now
	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	assign res.valid     = res_valid_q;
	assign res.out_byte  = res_byte_q;
	assign res.event_res = res_event_q;

	assign sum_plus = sum_q + byte_s1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_enable_q <= dledf_pkg::ChecksumEnableRst;
			escape_code_q     <= dledf_pkg::EscapeCodeRst;
			start_code_q      <= dledf_pkg::StartCodeRst;
			end_code_q        <= dledf_pkg::EndCodeRst;
		end else if (wr_en) begin
			unique case (dledf_pkg::reg_idx_t'(wr_index))
				dledf_pkg::REG_CHECKSUM_ENABLE: checksum_enable_q <= wr_data[0];
				dledf_pkg::REG_ESCAPE_CODE:     escape_code_q     <= wr_data[7:0];
				dledf_pkg::REG_START_CODE:      start_code_q      <= wr_data[7:0];
				dledf_pkg::REG_END_CODE:        end_code_q        <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// decode of the byte in the input register
	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		emit_d  = 1'b0;
		event_d = dledf_pkg::EV_PAYLOAD;
		unique case (phase_q)
			PH_START: begin
				if (byte_s1 == start_code_q) begin
					phase_d = PH_DATA;
					sum_d   = '0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_DATA: begin
				if (byte_s1 == escape_code_q) begin
					phase_d = PH_ESC;
				end else begin
					sum_d  = sum_plus;
					emit_d = 1'b1;
				end
			end
			PH_ESC: begin
				// a stuffed escape wins over the end test
				priority if (byte_s1 == escape_code_q) begin
					sum_d   = sum_plus;
					phase_d = PH_DATA;
					emit_d  = 1'b1;
				end else if (byte_s1 == end_code_q) begin
					if (checksum_enable_q) begin
						phase_d = PH_CHECK;
					end else begin
						phase_d = PH_HUNT;
						sum_d   = '0;
						emit_d  = 1'b1;
						event_d = dledf_pkg::EV_GOOD;
					end
				end else begin
					phase_d = PH_HUNT;
					emit_d  = 1'b1;
					event_d = dledf_pkg::EV_ABORT;
				end
			end
			PH_CHECK: begin
				phase_d = PH_HUNT;
				emit_d  = 1'b1;
				if (byte_s1 == ~sum_q) begin
					sum_d   = '0;
					event_d = dledf_pkg::EV_GOOD;
				end else begin
					event_d = dledf_pkg::EV_MISMATCH;
				end
			end
			default: begin
				// hunting, and any unused code
				phase_d = (byte_s1 == escape_code_q) ? PH_START : PH_HUNT;
			end
		endcase
	end

	// decoder state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
			res_byte_q  <= '0;
			res_event_q <= dledf_pkg::EV_PAYLOAD;
		end else if (advance) begin
			phase_q     <= phase_d;
			sum_q       <= sum_d;
			res_valid_q <= emit_d;
			if (emit_d) begin
				res_byte_q  <= byte_s1;
				res_event_q <= event_d;
			end
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

/* sim/tb_dle_stx_etx_deframer_checksum_unit.sv */
// self-checking testbench for the dle/stx/etx deframer with complement checksum
`timescale 1ns / 1ps

module tb_dle_stx_etx_deframer_checksum_unit;

	// run-away guard, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 400000;
	// quiet cycles after the last result so bytes that give no beat drain out
	localparam int unsigned DRAIN_CYCLES = 6;
	// length of the long receiver hold-off
	localparam int unsigned LONG_HOLD = 300;
	// minimum count of random bytes queued per random phase
	localparam int unsigned PHASE_ITEMS = 115;
	localparam int unsigned NUM_PHASES = 8;

	// decoder phases as the predictor tracks them
	typedef enum logic [2:0] {
		FR_HUNT,
		FR_OPEN,
		FR_BODY,
		FR_BODY_ESC,
		FR_WAIT_SUM
	} frame_phase_t;

	typedef struct packed {
		logic [7:0]        byte_val;
		dledf_pkg::event_t ev;
	} res_beat_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [dledf_pkg::RegIdxW-1:0] wr_index;
	logic [dledf_pkg::CfgDataW-1:0] wr_data;

	dledf_rx_if  rx_ch ();
	dledf_res_if res_ch ();

	dle_stx_etx_deframer_checksum_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.rx       (rx_ch),
		.res      (res_ch)
	);

	// mirror of the configuration registers
	logic       cs_enable;
	logic [7:0] esc_code;
	logic [7:0] sot_code;
	logic [7:0] eot_code;

	// predictor state
	frame_phase_t fr_phase;
	logic [7:0]   body_sum;

	// raw bytes waiting for the driver, decoded beats waiting for the monitor
	logic [7:0] raw_q[$];
	res_beat_t  decoded_q[$];

	int unsigned err_cnt;
	int unsigned cycle_cnt;
	int unsigned phase_items;

	// idling controls, set per phase by the sequencer
	bit snd_idle_on;
	bit rcv_idle_on;
	bit long_hold_req;

	// driver and monitor private counters
	int unsigned snd_gap;
	int unsigned rcv_wait;
	int unsigned long_hold_left;
	bit          long_hold_done;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// decode one accepted raw byte and queue the beat it causes, if any
	function automatic void deframe_byte(input logic [7:0] b);
		res_beat_t beat;
		bit        emit;
		emit = 1'b0;
		beat = '0;
		case (fr_phase)
			FR_OPEN: begin
				// start test wins here, even when start equals escape
				if (b == sot_code) begin
					fr_phase = FR_BODY;
					body_sum = 8'h00;
				end else begin
					fr_phase = FR_HUNT;
				end
			end
			FR_BODY: begin
				if (b == esc_code) begin
					fr_phase = FR_BODY_ESC;
				end else begin
					body_sum = body_sum + b;
					beat = '{b, dledf_pkg::EV_PAYLOAD};
					emit = 1'b1;
				end
			end
			FR_BODY_ESC: begin
				// stuffed escape beats the end test when both codes match
				if (b == esc_code) begin
					body_sum = body_sum + b;
					fr_phase = FR_BODY;
					beat = '{b, dledf_pkg::EV_PAYLOAD};
					emit = 1'b1;
				end else if (b == eot_code) begin
					if (cs_enable) begin
						fr_phase = FR_WAIT_SUM;
					end else begin
						fr_phase = FR_HUNT;
						body_sum = 8'h00;
						beat = '{b, dledf_pkg::EV_GOOD};
						emit = 1'b1;
					end
				end else begin
					fr_phase = FR_HUNT;
					beat = '{b, dledf_pkg::EV_ABORT};
					emit = 1'b1;
				end
			end
			FR_WAIT_SUM: begin
				// checksum byte closes the frame whatever the mode is now
				fr_phase = FR_HUNT;
				if (b == ~body_sum) begin
					body_sum = 8'h00;
					beat = '{b, dledf_pkg::EV_GOOD};
				end else begin
					beat = '{b, dledf_pkg::EV_MISMATCH};
				end
				emit = 1'b1;
			end
			default: begin
				fr_phase = (b == esc_code) ? FR_OPEN : FR_HUNT;
			end
		endcase
		if (emit)
			decoded_q.push_back(beat);
	endfunction

	// rx driver: one raw byte per beat, random gap after each accepted byte while snd_idle_on
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready)
				deframe_byte(rx_ch.rx_byte);
			// hold the byte while the block stalls us
			if (!(rx_ch.valid && !rx_ch.ready)) begin
				if (snd_gap > 0) begin
					snd_gap--;
					rx_ch.valid <= 1'b0;
				end else if (raw_q.size() > 0) begin
					rx_ch.rx_byte <= raw_q.pop_front();
					rx_ch.valid <= 1'b1;
					snd_gap = snd_idle_on ? $urandom_range(0, 15) : 0;
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// res monitor: check each beat against the oldest prediction, then pace ready
	always @(posedge clk) begin
		res_beat_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (decoded_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected beat: byte %h event %0d",
							res_ch.out_byte, res_ch.event_res);
				end else begin
					want = decoded_q.pop_front();
					if (res_ch.out_byte !== want.byte_val || res_ch.event_res !== want.ev) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: exp byte %h event %0d, got byte %h event %0d",
								want.byte_val, want.ev, res_ch.out_byte, res_ch.event_res);
					end
				end
				rcv_wait = rcv_idle_on ? $urandom_range(0, 15) : 0;
			end
			// long hold-off, counted here so the sender keeps pushing meanwhile
			if (long_hold_req && !long_hold_done) begin
				long_hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				res_ch.ready <= 1'b0;
			end else if (rcv_wait > 0) begin
				rcv_wait--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(input dledf_pkg::reg_idx_t idx, input logic [7:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			dledf_pkg::REG_CHECKSUM_ENABLE: cs_enable = val[0];
			dledf_pkg::REG_ESCAPE_CODE:     esc_code = val;
			dledf_pkg::REG_START_CODE:      sot_code = val;
			dledf_pkg::REG_END_CODE:        eot_code = val;
			default: ;
		endcase
	endtask

	task automatic set_codes(input bit cs, input logic [7:0] esc, input logic [7:0] sot,
			input logic [7:0] eot);
		write_reg(dledf_pkg::REG_CHECKSUM_ENABLE, {7'b0, cs});
		write_reg(dledf_pkg::REG_ESCAPE_CODE, esc);
		write_reg(dledf_pkg::REG_START_CODE, sot);
		write_reg(dledf_pkg::REG_END_CODE, eot);
	endtask

	// all bytes sent, all beats seen, then room for bytes that give no beat
	task automatic wait_drained();
		@(negedge clk);
		while (raw_q.size() != 0 || rx_ch.valid || decoded_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_raw(input logic [7:0] b);
		raw_q.push_back(b);
		phase_items++;
	endtask

	// payload byte, often one of the framing codes to hit the stuffing paths
	function automatic logic [7:0] pick_payload();
		case ($urandom_range(0, 9))
			0: return esc_code;
			1: return sot_code;
			2: return eot_code;
			3: return ~esc_code;
			default: return 8'($urandom());
		endcase
	endfunction

	// one frame with random content; bad_sum flips a checksum bit, cut ends in a bad escape
	task automatic queue_frame(input int unsigned len, input bit bad_sum, input bit cut);
		logic [7:0] sum;
		logic [7:0] b;
		sum = 8'h00;
		send_raw(esc_code);
		send_raw(sot_code);
		for (int unsigned i = 0; i < len; i++) begin
			b = pick_payload();
			sum = sum + b;
			send_raw(b);
			if (b == esc_code)
				send_raw(b);
		end
		send_raw(esc_code);
		if (cut) begin
			send_raw(8'($urandom()));
		end else begin
			send_raw(eot_code);
			if (cs_enable)
				send_raw(bad_sum ? ~sum ^ (8'h01 << $urandom_range(0, 7)) : ~sum);
		end
	endtask

	task automatic queue_bytes(input logic [7:0] seq[]);
		foreach (seq[i])
			send_raw(seq[i]);
	endtask

	initial begin
		int unsigned r;
		bit          cs;
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		res_ch.ready = 1'b0;
		cs_enable = dledf_pkg::ChecksumEnableRst;
		esc_code = dledf_pkg::EscapeCodeRst;
		sot_code = dledf_pkg::StartCodeRst;
		eot_code = dledf_pkg::EndCodeRst;
		fr_phase = FR_HUNT;
		body_sum = 8'h00;
		err_cnt = 0;
		cycle_cnt = 0;
		phase_items = 0;
		snd_idle_on = 1'b1;
		rcv_idle_on = 1'b1;
		long_hold_req = 1'b0;
		snd_gap = 0;
		rcv_wait = 0;
		long_hold_left = 0;
		long_hold_done = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset codes: good frame with a stuffed escape and extreme bytes,
		// escape-escape while hunting, then a frame left waiting for its checksum
		queue_bytes('{8'h10, 8'h02, 8'h00, 8'hFF, 8'h10, 8'h10, 8'h10, 8'h03, 8'hF0,
			8'h10, 8'h10, 8'h02,
			8'h10, 8'h02, 8'h7F, 8'h10, 8'h03});
		wait_drained();

		// checksum mode off mid-frame: the pending checksum byte is still checked,
		// next frame ends at the end pair
		write_reg(dledf_pkg::REG_CHECKSUM_ENABLE, 8'h00);
		queue_bytes('{8'h80, 8'h10, 8'h02, 8'h10, 8'h03});
		wait_drained();

		// escape equal to end code: a doubled escape stays payload, then a bad escape
		set_codes(1'b1, 8'h7E, 8'h00, 8'h7E);
		queue_bytes('{8'h7E, 8'h00, 8'h7E, 8'h7E, 8'h7E, 8'h99});
		wait_drained();

		// escape equal to start code, and a checksum mismatch
		set_codes(1'b1, 8'hFF, 8'hFF, 8'h00);
		queue_bytes('{8'hFF, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'h00});
		wait_drained();

		for (int unsigned p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: set_codes(1'b1, dledf_pkg::EscapeCodeRst, dledf_pkg::StartCodeRst,
					dledf_pkg::EndCodeRst);
				1: set_codes(1'b0, dledf_pkg::EscapeCodeRst, dledf_pkg::StartCodeRst,
					dledf_pkg::EndCodeRst);
				2: set_codes(1'b1, 8'h00, 8'hFF, 8'h80);
				3: set_codes(1'b0, 8'hFF, 8'h00, 8'h7F);
				4: set_codes(1'b1, 8'h55, 8'h55, 8'hAA);
				5: set_codes(1'b1, 8'h33, 8'h01, 8'h33);
				default: begin
					cs = $urandom_range(0, 1);
					set_codes(cs, 8'($urandom()), 8'($urandom()), 8'($urandom()));
				end
			endcase
			// sender back to back in the long-hold phase; one phase without any idling
			snd_idle_on = !(p == 0 || p == 3);
			rcv_idle_on = (p != 3);
			@(negedge clk);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					queue_frame($urandom_range(0, 10), $urandom_range(0, 4) == 0, 1'b0);
				else if (r < 80)
					repeat ($urandom_range(1, 4)) send_raw(8'($urandom()));
				else if (r < 90)
					queue_frame($urandom_range(0, 6), 1'b0, 1'b1);
				else
					// frame cut off before its end, the next one runs into it
					repeat ($urandom_range(2, 6)) send_raw(pick_payload());
			end
			if (p == 0)
				long_hold_req = 1'b1;
			wait_drained();
		end

		if (decoded_q.size() != 0) begin
			err_cnt++;
			$display("%0d predicted beats never arrived", decoded_q.size());
		end
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* dle_stx_etx_deframer_checksum_unit.f */
rtl/dledf_pkg.sv
rtl/dledf_rx_if.sv
rtl/dledf_res_if.sv
rtl/dle_stx_etx_deframer_checksum_unit.sv
sim/tb_dle_stx_etx_deframer_checksum_unit.sv
